### sv/cpba_pkg.sv
// ----------------------------------------------------------------------------
// Contiguous page bitmap allocator package
// Shared sizes, operation codes and transaction types.
// ----------------------------------------------------------------------------
package cpba_pkg;

  localparam int PAGES     = 256;
  localparam int WORD_BITS = 8;
  localparam int WORDS     = (PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int OFF_W     = $clog2(WORD_BITS);
  localparam int PAGE_W    = $clog2(PAGES);
  // Counter width: holds any page index, the page count itself and any
  // requested run length.
  localparam int CNT_W     = ((PAGE_W > 8) ? PAGE_W : 8) + 1;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_TEST  = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [8:0] run_length;
    logic [7:0] first_page;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] found_start;
    logic       page_busy;
  } rsp_t;

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] start;
    logic [CNT_W-1:0] run;
  } scan_res_t;

endpackage

### sv/cpba_word_scan.sv
// ----------------------------------------------------------------------------
// Word scanner
// Advances the free-run counter across one bitmap word and reports the
// first page at which the run reaches the requested length.
// ----------------------------------------------------------------------------
module cpba_word_scan (
  input  logic [cpba_pkg::WORD_BITS-1:0] word_i,
  input  logic [cpba_pkg::CNT_W-1:0]     base_i,
  input  logic [cpba_pkg::CNT_W-1:0]     run_i,
  input  logic [cpba_pkg::CNT_W-1:0]     len_i,
  output cpba_pkg::scan_res_t            res_o
);
  import cpba_pkg::*;

  always_comb begin
    logic [CNT_W-1:0] run;
    logic [CNT_W-1:0] pg;
    logic             hit;
    logic [CNT_W-1:0] start;
    run   = run_i;
    hit   = 1'b0;
    start = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      pg = base_i + CNT_W'(b);
      // Padding bits past the last page count as busy.
      if (word_i[b] || (pg >= CNT_W'(PAGES))) begin
        run = '0;
      end else begin
        run = run + CNT_W'(1);
      end
      if (!hit && (run == len_i)) begin
        hit   = 1'b1;
        start = pg + CNT_W'(1) - len_i;
      end
    end
    res_o.hit   = hit;
    res_o.start = start;
    res_o.run   = run;
  end

endmodule

### sv/contiguous_page_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// Contiguous page bitmap allocator
// First-fit allocator over a one-bit-per-page busy map held in a word memory.
// ----------------------------------------------------------------------------
// The block handles one request transaction at a time and returns exactly one
// response transaction for each. The busy map lives in a word memory of eight
// pages per word with a registered read, and every word is first read and then
// evaluated or written back. An allocate scans from word 0 upwards, reading and
// evaluating each word, then reads and writes back each word of the run it
// marks busy and ends in a closing check that finds the run complete. A free
// reads and writes back each word it clears and ends in the same closing
// check, a test reads and evaluates one word, and a rejected allocate (zero or
// oversized length) or an unused operation code goes straight to the
// response. The response register is then loaded. Reset clears a valid bit per
// word, so the map reads as all free at once and there is no clearing pass.
// The next request is taken as soon as the previous response has been loaded,
// even if it has not yet been taken downstream.
// ----------------------------------------------------------------------------
module contiguous_page_bitmap_allocator_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cpba_pkg::req_t   in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cpba_pkg::rsp_t   out_rsp_o
);
  import cpba_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN_RD = 3'd1;
  localparam logic [2:0] ST_SCAN_EV = 3'd2;
  localparam logic [2:0] ST_MOD_RD  = 3'd3;
  localparam logic [2:0] ST_MOD_WR  = 3'd4;
  localparam logic [2:0] ST_TEST_RD = 3'd5;
  localparam logic [2:0] ST_TEST_EV = 3'd6;
  localparam logic [2:0] ST_RESP    = 3'd7;

  // Busy map memory and per-word valid bits. A word whose valid bit is clear
  // has never been written since reset and reads as all free.
  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]     word_vld_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rvld_q;
  logic [WORD_AW-1:0]   rd_addr;
  logic [WORD_BITS-1:0] rword;

  logic [2:0]         state_q, state_d;
  logic [WORD_AW-1:0] scan_w_q, scan_w_d;
  logic [CNT_W-1:0]   run_q, run_d;
  logic [CNT_W-1:0]   len_q, len_d;
  logic [CNT_W-1:0]   cur_q, cur_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic               set_q, set_d;
  rsp_t               res_q, res_d;
  logic               out_valid_q;
  rsp_t               out_q;

  scan_res_t            scan;
  logic [CNT_W-1:0]     req_len;
  logic [CNT_W-1:0]     req_page;
  logic [WORD_AW-1:0]   cur_word;
  logic [OFF_W-1:0]     cur_off;
  logic [CNT_W-1:0]     avail;
  logic [CNT_W-1:0]     chunk;
  logic [CNT_W-1:0]     hi;
  logic [WORD_BITS-1:0] mask;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wdata;
  logic                 resp_load;

  assign req_len  = CNT_W'(in_req_i.run_length);
  assign req_page = CNT_W'(in_req_i.first_page);
  assign cur_word = cur_q[OFF_W +: WORD_AW];
  assign cur_off  = cur_q[OFF_W-1:0];
  assign rword    = rvld_q ? rdata_q : '0;

  // The scanner sees the word fetched in the previous cycle.
  cpba_word_scan u_scan (
    .word_i (rword),
    .base_i (CNT_W'({scan_w_q, {OFF_W{1'b0}}})),
    .run_i  (run_q),
    .len_i  (len_q),
    .res_o  (scan)
  );

  // Part of the current word covered by the run being marked or cleared.
  always_comb begin
    avail = CNT_W'(WORD_BITS) - CNT_W'(cur_off);
    chunk = (rem_q < avail) ? rem_q : avail;
    hi    = CNT_W'(cur_off) + chunk;
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (CNT_W'(i) >= CNT_W'(cur_off)) && (CNT_W'(i) < hi);
    end
    wdata = set_q ? (rword | mask) : (rword & ~mask);
  end

  always_comb begin
    case (state_q)
      ST_SCAN_RD: rd_addr = scan_w_q;
      default:    rd_addr = cur_word;
    endcase
  end

  assign wr_en     = (state_q == ST_MOD_WR);
  assign resp_load = (state_q == ST_RESP) && (!out_valid_q || !out_stall_i);

  // Sequencer. A write-back also reads its word in the same cycle, but that read
  // is discarded: each write completes before the next read of the map is used.
  always_comb begin
    state_d  = state_q;
    scan_w_d = scan_w_q;
    run_d    = run_q;
    len_d    = len_q;
    cur_d    = cur_q;
    rem_d    = rem_q;
    set_d    = set_q;
    res_d    = res_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_d = '0;
          len_d = req_len;
          cur_d = req_page;
          rem_d = req_len;
          case (in_req_i.func)
            FUNC_ALLOC: begin
              if ((req_len == '0) || (req_len > CNT_W'(PAGES))) begin
                state_d = ST_RESP;
              end else begin
                scan_w_d = '0;
                run_d    = '0;
                state_d  = ST_SCAN_RD;
              end
            end
            FUNC_FREE: begin
              res_d.ok = 1'b1;
              set_d    = 1'b0;
              state_d  = ST_MOD_RD;
            end
            FUNC_TEST: begin
              res_d.ok = 1'b1;
              if (req_page >= CNT_W'(PAGES)) begin
                state_d = ST_RESP;
              end else begin
                state_d = ST_TEST_RD;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        run_d = scan.run;
        if (scan.hit) begin
          res_d.ok          = 1'b1;
          res_d.found_start = scan.start[7:0];
          cur_d             = scan.start;
          rem_d             = len_q;
          set_d             = 1'b1;
          state_d           = ST_MOD_RD;
        end else if (scan_w_q == WORD_AW'(WORDS - 1)) begin
          state_d = ST_RESP;
        end else begin
          scan_w_d = scan_w_q + WORD_AW'(1);
          state_d  = ST_SCAN_RD;
        end
      end
      ST_MOD_RD: begin
        if ((rem_q == '0) || (cur_q >= CNT_W'(PAGES))) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_MOD_WR;
        end
      end
      ST_MOD_WR: begin
        cur_d   = cur_q + chunk;
        rem_d   = rem_q - chunk;
        state_d = ST_MOD_RD;
      end
      ST_TEST_RD: begin
        state_d = ST_TEST_EV;
      end
      ST_TEST_EV: begin
        res_d.page_busy = rword[cur_off];
        state_d         = ST_RESP;
      end
      ST_RESP: begin
        if (resp_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Memory array: one read and at most one write per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cur_word] <= wdata;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_vld_q <= '0;
      rvld_q     <= 1'b0;
    end else begin
      // A write in this cycle lands before the next read is issued.
      rvld_q <= word_vld_q[rd_addr];
      if (wr_en) begin
        word_vld_q[cur_word] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (resp_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_w_q <= scan_w_d;
    run_q    <= run_d;
    len_q    <= len_d;
    cur_q    <= cur_d;
    rem_q    <= rem_d;
    set_q    <= set_d;
    res_q    <= res_d;
    if (resp_load) begin
      out_q <= res_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // A write-back only ever targets a page inside the map.
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD_WR) |-> (cur_q < CNT_W'(PAGES)))
    else $error("write-back cursor beyond the last page");

  // A run found by the scan lies entirely inside the map.
  a_hit_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN_EV) && scan.hit) |->
      (({1'b0, scan.start} + {1'b0, len_q}) <= (CNT_W + 1)'(PAGES)))
    else $error("allocated run extends past the last page");

  // An accepted request always starts work.
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))
    else $error("accepted request left the sequencer idle");

  // A new response is only loaded from the response state.
  a_resp_from_resp_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_RESP))
    else $error("response raised outside the response state");

endmodule
